// File: sv/streaming_vector_quantizer_core_defines.svh
// Assertion macros for the port-level checker of the vector quantizer.
// No dependencies.
`ifndef STREAMING_VECTOR_QUANTIZER_CORE_DEFINES_SVH
`define STREAMING_VECTOR_QUANTIZER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SVQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("violation: label");
// Implication whose consequence is checked in the cycle after the antecedent.
`define SVQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("violation: label");
`endif

// File: sv/svq_pkg.sv
// Types and constants for the streaming vector quantizer.
// No dependencies.
`timescale 1ns / 1ps
package svq_pkg;
   typedef struct packed {
      logic signed [15:0] component;
      logic [15:0]        sample_weight;
      logic [15:0]        random_fraction;
   } req_type;

   typedef struct packed {
      logic [3:0]  center_index;
      logic [1:0]  action;
      logic [39:0] nearest_cost;
      logic [4:0]  center_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ACT_UPDATED = 2'd0,
      ACT_ADDED   = 2'd1,
      ACT_FULL    = 2'd2
   } action_type;

   localparam logic [1:0] CSR_COST_BOUND   = 2'd0;
   localparam logic [1:0] CSR_DIMENSION    = 2'd1;
   localparam logic [1:0] CSR_CENTER_LIMIT = 2'd2;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [47:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [47:0] quotient;
   } div_rsp_type;
endpackage

// File: sv/svq_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on svq_pkg.
`timescale 1ns / 1ps
module svq_divider (
   input  logic                clock,
   input  logic                reset,
   input  svq_pkg::div_cmd_type cmd,
   output svq_pkg::div_rsp_type rsp
);
   import svq_pkg::*;

   logic [47:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[47]};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         den_in  = cmd.divisor;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

// File: sv/streaming_vector_quantizer_core.sv
// Streaming vector quantizer (online leader clustering). Samples arrive one
// component per item; the last component carries weight and random fraction.
// A non-final component is only buffered. A final component starts a
// sequencer: one shared squared-difference accumulator walks every center in
// use and every dimension, one component per cycle through a memory read,
// square and accumulate pipeline per center. Creating a center copies the
// sample in; moving one runs the one-bit-per-cycle divider for each
// dimension. Once the store is full, a final component gets its result with
// no search. No result is given for non-final components. Depends on svq_pkg.
`timescale 1ns / 1ps
module streaming_vector_quantizer_core #(
   parameter int MAX_CENTERS = 16,
   parameter int MAX_DIM     = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  svq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output svq_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [47:0]      csr_data
);
   import svq_pkg::*;

   localparam int CW = $clog2(MAX_CENTERS) > 0 ? $clog2(MAX_CENTERS) : 1;
   localparam int DW = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
   localparam int NW = $clog2(MAX_CENTERS + 1);
   localparam int AW = CW + DW;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_FIRST = 11'b00000000010,
      ST_RD    = 11'b00000000100,
      ST_ACC   = 11'b00000001000,
      ST_CMP   = 11'b00000010000,
      ST_TEST  = 11'b00000100000,
      ST_WRITE = 11'b00001000000,
      ST_MRD   = 11'b00010000000,
      ST_MDIV  = 11'b00100000000,
      ST_MWR   = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [47:0] bound_ff;
   logic [6:0]  dim_reg_ff;
   logic [4:0]  lim_reg_ff;
   logic [DW:0] dim_eff;
   logic [NW-1:0] lim_eff;

   always_comb begin
      if (dim_reg_ff == 7'd0) dim_eff = (DW + 1)'(1);
      else if (32'(dim_reg_ff) > MAX_DIM) dim_eff = (DW + 1)'(MAX_DIM);
      else dim_eff = (DW + 1)'(dim_reg_ff);
      if (lim_reg_ff == 5'd0) lim_eff = NW'(1);
      else if (32'(lim_reg_ff) > MAX_CENTERS) lim_eff = NW'(MAX_CENTERS);
      else lim_eff = NW'(lim_reg_ff);
   end

   // memories
   logic [31:0] center_mem [MAX_CENTERS*MAX_DIM];
   logic [31:0] weight_mem [MAX_CENTERS];
   logic [15:0] sample_mem [MAX_DIM];

   // control state
   logic [DW-1:0] pos_ff;
   logic [NW-1:0] used_ff;
   logic          stop_ff;
   logic [15:0]   xw_ff;
   logic [15:0]   rf_ff;
   logic [CW-1:0] cidx_ff;
   logic [DW:0]   j_ff;
   logic [DW:0]   jr_ff;
   logic [1:0]    pipe_ff;
   logic [55:0]   sum_ff;
   logic [55:0]   best_ff;
   logic [CW-1:0] bidx_ff;
   logic          mult_v_ff;
   logic [63:0]   sq_ff;
   logic          rd_v_ff;
   logic [31:0]   crd_ff;
   logic [15:0]   srd_ff;
   logic [31:0]   wrd_ff;
   logic [31:0]   cw_ff;
   logic          dneg_ff;
   logic [31:0]   cv_ff;
   logic          div_go_ff;
   rsp_type       out_ff;
   logic          out_v_ff;
   logic [1:0]    act_ff;
   logic [39:0]   cost_ff;
   logic [55:0]   lhs_ff;
   logic [63:0]   prod_ff;
   logic [1:0]    tst_ff;

   div_cmd_type div_cmd;
   div_rsp_type div_rsp;
   svq_divider u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .rsp(div_rsp));

   assign req_stall = (state_ff != ST_IDLE) || out_v_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   logic req_acc;
   logic last_comp;
   assign req_acc   = req_valid && !req_stall;
   assign last_comp = (DW + 1)'(pos_ff) + (DW + 1)'(1) >= dim_eff;

   // read addresses
   logic [AW-1:0] raddr;
   logic [DW-1:0] jrd;
   assign jrd   = j_ff[DW-1:0];
   assign raddr = {cidx_ff, jrd};

   always_ff @(posedge clock) begin
      crd_ff <= center_mem[raddr];
      srd_ff <= sample_mem[jrd];
      wrd_ff <= weight_mem[cidx_ff];
   end

   // shared squared-difference unit
   logic signed [33:0] diff;
   logic [32:0]        mag;
   assign diff = 34'(signed'(crd_ff)) - 34'({{2{srd_ff[15]}}, srd_ff, 16'd0});
   assign mag  = diff[33] ? 33'(-diff) : diff[32:0];

   // move arithmetic
   logic signed [33:0] mdiff;
   logic [32:0]        mmag;
   logic [47:0]        mnum;
   logic [32:0]        cwsum;
   assign mdiff = 34'({{2{srd_ff[15]}}, srd_ff, 16'd0}) - 34'(signed'(crd_ff));
   assign mmag  = mdiff[33] ? 33'(-mdiff) : mdiff[32:0];
   assign mnum  = 48'(mmag) * 48'(xw_ff) + 48'(cw_ff >> 1);
   assign cwsum = 33'(wrd_ff) + 33'(xw_ff);

   always_comb begin
      div_cmd.start    = div_go_ff;
      div_cmd.dividend = mnum;
      div_cmd.divisor  = cw_ff;
   end

   logic [31:0] moved;
   assign moved = dneg_ff ? cv_ff - div_rsp.quotient[31:0] : cv_ff + div_rsp.quotient[31:0];

   always_ff @(posedge clock) begin
      if (req_acc) sample_mem[pos_ff] <= req_data.component;
      if (state_ff == ST_WRITE && rd_v_ff)
         center_mem[{cidx_ff, jr_ff[DW-1:0]}] <= {srd_ff, 16'd0};
      if (state_ff == ST_MWR)
         center_mem[{cidx_ff, jr_ff[DW-1:0]}] <= moved;
      if ((state_ff == ST_WRITE && j_ff == '0 && !rd_v_ff) || state_ff == ST_MRD && pipe_ff == 2'd0
          && j_ff == '0 && jr_ff == '0)
         weight_mem[cidx_ff] <= (state_ff == ST_WRITE) ? 32'(xw_ff)
                                : (cwsum[32] ? 32'hFFFF_FFFF : cwsum[31:0]);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_acc && last_comp) begin
            if (stop_ff) state_in = ST_OUT;
            else if (used_ff == '0) state_in = ST_FIRST;
            else state_in = ST_RD;
         end
         ST_FIRST: state_in = ST_WRITE;
         ST_RD:    state_in = ST_ACC;
         ST_ACC:   if (j_ff == dim_eff && !mult_v_ff && !rd_v_ff) state_in = ST_CMP;
         ST_CMP:   if ((NW)'(cidx_ff) + NW'(1) >= used_ff) state_in = ST_TEST;
                   else state_in = ST_RD;
         ST_TEST:  if (tst_ff == 2'd2) begin
            if (act_ff == ACT_UPDATED) state_in = ST_MRD;
            else if (act_ff == ACT_ADDED) state_in = ST_WRITE;
            else state_in = ST_OUT;
         end
         ST_WRITE: if (rd_v_ff && jr_ff + 1'b1 >= dim_eff) state_in = ST_OUT;
         ST_MRD:   if (pipe_ff == 2'd2) state_in = (cw_ff == '0) ? ST_OUT : ST_MDIV;
         ST_MDIV:  if (div_rsp.done) state_in = ST_MWR;
         ST_MWR:   state_in = (jr_ff + 1'b1 >= dim_eff) ? ST_OUT : ST_MRD;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   logic [55:0] best_sum;
   assign best_sum = (cidx_ff == '0 || sum_ff < best_ff) ? sum_ff : best_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bound_ff   <= '0;
         dim_reg_ff <= 7'd1;
         lim_reg_ff <= 5'd16;
         pos_ff     <= '0;
         used_ff    <= '0;
         stop_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
         div_go_ff  <= 1'b0;
         mult_v_ff  <= 1'b0;
         rd_v_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COST_BOUND:   bound_ff   <= csr_data;
               CSR_DIMENSION:    dim_reg_ff <= csr_data[6:0];
               CSR_CENTER_LIMIT: lim_reg_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         if (out_v_ff && !rsp_stall) out_v_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (req_acc) begin
               if (last_comp) begin
                  pos_ff  <= '0;
                  xw_ff   <= req_data.sample_weight;
                  rf_ff   <= req_data.random_fraction;
                  cidx_ff <= '0;
                  j_ff    <= '0;
                  sum_ff  <= '0;
                  act_ff  <= ACT_FULL;
                  cost_ff <= '0;
                  bidx_ff <= '0;
               end else if (32'(pos_ff) < MAX_DIM - 1) begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            ST_FIRST: begin
               act_ff  <= ACT_ADDED;
               used_ff <= NW'(1);
               rd_v_ff <= 1'b0;
            end
            ST_RD: begin
               j_ff      <= j_ff + 1'b1;
               pipe_ff   <= 2'd0;
               mult_v_ff <= 1'b0;
               rd_v_ff   <= 1'b1;
            end
            ST_ACC: begin
               // issue reads, square, accumulate in lockstep
               if (j_ff != dim_eff) j_ff <= j_ff + 1'b1;
               rd_v_ff   <= (j_ff != dim_eff);
               mult_v_ff <= rd_v_ff;
               if (rd_v_ff) sq_ff <= 64'(mag) * 64'(mag);
               if (mult_v_ff) sum_ff <= sum_ff + 56'(sq_ff >> 16);
               pipe_ff <= (rd_v_ff || mult_v_ff) ? 2'd1 : 2'd0;
            end
            ST_CMP: begin
               best_ff <= best_sum;
               if (cidx_ff == '0 || sum_ff < best_ff) bidx_ff <= cidx_ff;
               sum_ff  <= '0;
               j_ff    <= '0;
               rd_v_ff <= 1'b0;
               if ((NW)'(cidx_ff) + NW'(1) < used_ff) cidx_ff <= cidx_ff + 1'b1;
               tst_ff  <= 2'd0;
            end
            ST_TEST: begin
               tst_ff <= tst_ff + 2'd1;
               if (tst_ff == 2'd0) begin
                  cost_ff <= best_ff[55:16];
                  lhs_ff  <= 56'(xw_ff) * 56'(best_ff[55:16]);
                  prod_ff <= 64'(rf_ff) * 64'(bound_ff);
               end
               if (tst_ff == 2'd1) begin
                  j_ff  <= '0;
                  jr_ff <= '0;
                  if (prod_ff != '0 && 64'(lhs_ff) <= ((prod_ff - 64'd1) >> 16)) begin
                     act_ff  <= ACT_UPDATED;
                     cidx_ff <= bidx_ff;
                  end else if (used_ff >= lim_eff) begin
                     act_ff  <= ACT_FULL;
                     cidx_ff <= bidx_ff;
                     stop_ff <= 1'b1;
                  end else begin
                     act_ff  <= ACT_ADDED;
                     cidx_ff <= CW'(used_ff);
                     used_ff <= used_ff + NW'(1);
                  end
                  pipe_ff <= 2'd0;
                  rd_v_ff <= 1'b0;
               end
            end
            ST_WRITE: begin
               // copy the buffered sample into the new center
               rd_v_ff <= 1'b1;
               jr_ff   <= j_ff;
               j_ff    <= j_ff + 1'b1;
            end
            ST_MRD: begin
               pipe_ff <= pipe_ff + 2'd1;
               if (pipe_ff == 2'd1 && jr_ff == '0) cw_ff <= cwsum[32] ? 32'hFFFF_FFFF : cwsum[31:0];
               if (pipe_ff == 2'd2) begin
                  dneg_ff   <= mdiff[33];
                  cv_ff     <= crd_ff;
                  div_go_ff <= (cw_ff != '0);
                  pipe_ff   <= 2'd0;
               end
            end
            ST_MDIV: ;
            ST_MWR: begin
               jr_ff <= jr_ff + 1'b1;
               j_ff  <= jr_ff + 1'b1;
            end
            ST_OUT: begin
               out_v_ff            <= 1'b1;
               out_ff.center_index <= 4'(cidx_ff);
               out_ff.action       <= act_ff;
               out_ff.nearest_cost <= cost_ff;
               out_ff.center_count <= 5'(used_ff);
               if (stop_ff && act_ff != ACT_FULL) out_ff.action <= act_ff;
               if (act_ff == ACT_FULL && cost_ff == '0 && used_ff != '0 && !stop_ff)
                  out_ff.center_index <= 4'(cidx_ff);
            end
            default: ;
         endcase
         // stopped samples report index zero
         if (state_ff == ST_IDLE && req_acc && last_comp && stop_ff) cidx_ff <= '0;
      end
   end
endmodule

// File: sv/svq_checker.sv
// Port-level checker for the vector quantizer, bound to the top level.
// Depends on svq_pkg and streaming_vector_quantizer_core_defines.svh.
`timescale 1ns / 1ps
`include "streaming_vector_quantizer_core_defines.svh"
module svq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input svq_pkg::rsp_type rsp_data
);
   import svq_pkg::*;
   `SVQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `SVQ_ASSERT_IMPLY(a_no_take_while_out, clock, reset, rsp_valid, req_stall)
   `SVQ_ASSERT_IMPLY(a_action_code, clock, reset, rsp_valid, rsp_data.action != 2'd3)
   `SVQ_ASSERT_IMPLY(a_count_range, clock, reset, rsp_valid, rsp_data.center_count <= 5'd16)
endmodule

bind streaming_vector_quantizer_core svq_checker u_svq_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

// File: tb/streaming_vector_quantizer_core_checker.sv
// Checker for the streaming vector quantizer: tracks CSR writes and accepted
// items, predicts each sample's result and compares it. Depends on svq_pkg.
`timescale 1ns / 1ps
module streaming_vector_quantizer_core_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  svq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  svq_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [47:0]      csr_data,
   output int               errors,
   output int               pending
);
   import svq_pkg::*;

   localparam int NCTR = 16;
   localparam int NDIM = 64;

   logic signed [31:0] centers [NCTR][NDIM];
   logic [31:0]        weights [NCTR];
   logic signed [15:0] sample [NDIM];
   int                 used;
   int                 position;
   bit                 halted;
   logic [47:0]        bound;
   logic [6:0]         dim_reg;
   logic [4:0]         limit_reg;
   rsp_type            expected_q [$];

   function automatic int active_dim();
      if (dim_reg == 0) return 1;
      if (dim_reg > NDIM) return NDIM;
      return dim_reg;
   endfunction

   function automatic int active_limit();
      if (limit_reg == 0) return 1;
      if (limit_reg > NCTR) return NCTR;
      return limit_reg;
   endfunction

   // Q.16 squared distance from center c to the buffered sample
   function automatic logic [63:0] distance_q16(int c, int n);
      logic [63:0]  acc;
      longint       d;
      logic [127:0] m;
      acc = 0;
      for (int j = 0; j < n; j++) begin
         d   = longint'(centers[c][j]) - longint'(sample[j]) * 65536;
         m   = (d < 0) ? 128'(-d) : 128'(d);
         acc += 64'((m * m) >> 16);
      end
      return acc;
   endfunction

   function automatic void place_center(int c, int n, logic [31:0] w);
      for (int j = 0; j < n; j++) centers[c][j] = 32'(longint'(sample[j]) * 65536);
      weights[c] = w;
   endfunction

   // weighted running mean, quotient rounded half away from zero
   function automatic void pull_center(int c, int n, logic [15:0] w);
      logic [63:0] cw, mag, prod, q;
      longint      cv, d;
      cw = 64'(weights[c]) + 64'(w);
      if (cw > 64'hFFFF_FFFF) cw = 64'hFFFF_FFFF;
      weights[c] = cw[31:0];
      if (cw == 0) return;
      for (int j = 0; j < n; j++) begin
         cv   = longint'(centers[c][j]);
         d    = longint'(sample[j]) * 65536 - cv;
         mag  = (d < 0) ? 64'(-d) : 64'(d);
         prod = mag * 64'(w);
         q    = (prod + cw / 2) / cw;
         cv   = (d < 0) ? cv - longint'(q) : cv + longint'(q);
         centers[c][j] = cv[31:0];
      end
   endfunction

   function automatic void absorb_item(req_type it);
      int          n, pos, best_idx, cnt;
      logic [63:0] best, s, cost, lhs, p;
      rsp_type     r;
      bit          near;
      n   = active_dim();
      pos = (position >= NDIM) ? NDIM - 1 : position;
      sample[pos] = it.component;
      if (pos + 1 < n) begin
         position = pos + 1;
         return;
      end
      position = 0;
      best_idx = 0;
      cost     = 0;
      r.action = ACT_FULL;
      if (halted) begin
      end else if (used == 0) begin
         place_center(0, n, 32'(it.sample_weight));
         used     = 1;
         r.action = ACT_ADDED;
      end else begin
         cnt  = (used > NCTR) ? NCTR : used;
         best = distance_q16(0, n);
         for (int c = 1; c < cnt; c++) begin
            s = distance_q16(c, n);
            if (s < best) begin
               best     = s;
               best_idx = c;
            end
         end
         cost = best >> 16;
         lhs  = 64'(it.sample_weight) * cost;
         p    = 64'(it.random_fraction) * 64'(bound);
         near = (p != 0) && (lhs <= ((p - 1) >> 16));
         if (near) begin
            pull_center(best_idx, n, it.sample_weight);
            r.action = ACT_UPDATED;
         end else if (cnt >= active_limit()) begin
            halted = 1;
         end else begin
            place_center(cnt, n, 32'(it.sample_weight));
            used     = cnt + 1;
            best_idx = cnt;
            r.action = ACT_ADDED;
         end
      end
      r.center_index = 4'(best_idx);
      r.nearest_cost = cost[39:0];
      r.center_count = 5'(used);
      expected_q.push_back(r);
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         used      = 0;
         position  = 0;
         halted    = 0;
         bound     = '0;
         dim_reg   = 7'd1;
         limit_reg = 5'd16;
         errors    <= 0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COST_BOUND:   bound     = csr_data;
               CSR_DIMENSION:    dim_reg   = csr_data[6:0];
               CSR_CENTER_LIMIT: limit_reg = csr_data[4:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) absorb_item(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               if (errors < 10) $display("unexpected result %p", rsp_data);
               errors <= errors + 1;
            end else begin
               want = expected_q.pop_front();
               if (want !== rsp_data) begin
                  if (errors < 10)
                     $display("mismatch: idx %0d/%0d act %0d/%0d cost %0d/%0d cnt %0d/%0d",
                              want.center_index, rsp_data.center_index,
                              want.action, rsp_data.action,
                              want.nearest_cost, rsp_data.nearest_cost,
                              want.center_count, rsp_data.center_count);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule

// File: tb/streaming_vector_quantizer_core_tb.sv
// Top of the vector quantizer testbench: clock, reset, CSR phases, sample
// stimulus and verdict. Depends on svq_pkg, the checker and the core.
`timescale 1ns / 1ps
module streaming_vector_quantizer_core_tb;
   import svq_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [1:0]  csr_index;
   logic [47:0] csr_data;
   int      errors;
   int      pending;
   int      seen_centers;

   streaming_vector_quantizer_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   streaming_vector_quantizer_core_checker u_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .errors(errors), .pending(pending)
   );

   always #5 clock = ~clock;

   // Track the center count the block reports, so random stimulus can steer
   // away from filling the store before the final phase.
   always @(posedge clock) begin
      if (reset) seen_centers <= 0;
      else if (rsp_valid && !rsp_stall) seen_centers <= rsp_data.center_count;
   end

   // Receiver back-pressure: runs of stall and free cycles, mostly short.
   initial begin
      int run;
      bit stalling;
      rsp_stall = 0;
      stalling  = 0;
      forever begin
         if (stalling) run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                          : $urandom_range(1, 3);
         else          run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(1, 10);
         @(negedge clock);
         rsp_stall <= stalling;
         repeat (run - 1) @(negedge clock);
         stalling = ~stalling;
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Hold the item until accepted; drop valid only when a gap follows.
   task automatic push_item(req_type it);
      int gap;
      req_valid <= 1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [47:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // Wait out every expected result, then let the block sit idle.
   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (4000) @(negedge clock);
   endtask

   // One sample of n components. spread picks the component range; w and frac
   // ride on the last component only.
   task automatic push_sample(int n, int spread, logic [15:0] w, logic [15:0] frac);
      req_type it;
      for (int j = 0; j < n; j++) begin
         it.component       = (spread >= 32768) ? 16'($urandom)
                                                : 16'($urandom_range(0, 2 * spread) - spread);
         it.sample_weight   = (j == n - 1) ? w : 16'($urandom);
         it.random_fraction = (j == n - 1) ? frac : 16'($urandom);
         push_item(it);
      end
   endtask

   task automatic random_samples(int n, int count);
      logic [15:0] w, frac;
      int spread;
      for (int k = 0; k < count; k++) begin
         w      = 16'($urandom);
         frac   = 16'($urandom);
         spread = ($urandom_range(0, 2) == 0) ? 32768 : $urandom_range(1, 400);
         if (seen_centers >= 12) begin
            w    = 16'd0;
            frac = 16'($urandom_range(1, 65535));
         end
         push_sample(n, spread, w, frac);
      end
   endtask

   initial begin
      req_type it;
      clock     = 0;
      reset     = 1;
      req_valid = 0;
      req_data  = '0;
      csr_valid = 0;
      csr_index = CSR_COST_BOUND;
      csr_data  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Widest dimension first: centers never grow into unwritten entries.
      write_csr(CSR_DIMENSION, 48'd127);
      write_csr(CSR_CENTER_LIMIT, 48'd16);
      write_csr(CSR_COST_BOUND, 48'hFFFF_FFFF_FFFF);
      // first sample at the extremes with zero weight: becomes center 0
      for (int j = 0; j < 64; j++) begin
         it.component       = j[0] ? 16'sh7FFF : 16'sh8000;
         it.sample_weight   = j[0] ? 16'hFFFF : 16'h0000;
         it.random_fraction = j[0] ? 16'h0000 : 16'hFFFF;
         if (j == 63) it.sample_weight = 16'h0000;
         push_item(it);
      end
      // zero cumulative weight: near, but the center must stay put
      push_sample(64, 32768, 16'd0, 16'hFFFF);
      // zero fraction never counts as near: add a center
      push_sample(64, 32768, 16'hFFFF, 16'd0);
      // heavy update at full bound
      push_sample(64, 32768, 16'hFFFF, 16'hFFFF);
      drain();

      write_csr(CSR_DIMENSION, 48'd8);
      write_csr(CSR_COST_BOUND, 48'($urandom) << 16 | 48'($urandom_range(1, 65535)));
      random_samples(8, 35);
      // hold off until the block has answered everything
      while (pending != 0) @(negedge clock);
      random_samples(8, 35);
      drain();

      write_csr(CSR_DIMENSION, 48'd3);
      write_csr(CSR_CENTER_LIMIT, 48'd31);
      write_csr(CSR_COST_BOUND, 48'd1);
      random_samples(3, 50);
      drain();
      write_csr(CSR_COST_BOUND, {16'($urandom), 32'($urandom)} | 48'd1);
      random_samples(3, 50);
      drain();

      write_csr(CSR_DIMENSION, 48'd0);
      write_csr(CSR_COST_BOUND, 48'h0000_0001_0000);
      random_samples(1, 80);
      drain();

      // Smallest limit and zero bound: the next sample finds the store full.
      write_csr(CSR_CENTER_LIMIT, 48'd0);
      write_csr(CSR_COST_BOUND, 48'd0);
      for (int k = 0; k < 30; k++) push_sample(1, 32768, 16'($urandom), 16'($urandom));
      drain();

      if (errors == 0 && pending == 0) begin
         $display("streaming_vector_quantizer_core verification clean");
      end else begin
         $display("streaming_vector_quantizer_core verification failed");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("streaming_vector_quantizer_core verification failed");
      $finish;
   end
endmodule
